FILE: hdl/s2rd_pkg.sv
// Shared types, constants and digit encoding for the signed-to-radix converter.
package s2rd_pkg;

  localparam int MAG_W    = 64;              // magnitude / value width
  localparam int RADIX_W  = 6;               // radix and digit width
  localparam int CHAR_W   = 8;               // ASCII character width
  localparam int IN_TDATA_W  = 72;           // value + radix, padded to bytes
  localparam int OUT_TDATA_W = 8;

  // Divider: quotient bits retired per cycle and resulting cycle count
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = MAG_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;  // '-'

  localparam logic [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};

  // Result of one division pass
  typedef struct packed {
    logic               done;
    logic [MAG_W-1:0]   quot;
    logic [RADIX_W-1:0] rem;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

FILE: hdl/s2rd_divider.sv
// Iterative shift-subtract divider: 64-bit magnitude by a 6-bit radix.
module s2rd_divider
  import s2rd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MAG_W-1:0]   dividend,
  input  logic [RADIX_W-1:0] divisor,
  output div_res_t           res
);

  logic [MAG_W-1:0]     quot_r, quot_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   dsor_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;

  // Retire DIV_STEP quotient bits, most significant first
  always_comb begin
    logic [RADIX_W:0]    t;
    logic [RADIX_W-1:0]  rem_v;
    logic [DIV_STEP-1:0] qbits;
    rem_v = rem_r;
    qbits = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {rem_v, quot_r[MAG_W-1-k]};
      if (t >= {1'b0, dsor_r}) begin
        t = t - {1'b0, dsor_r};
        qbits[DIV_STEP-1-k] = 1'b1;
      end
      rem_v = t[RADIX_W-1:0];
    end
    rem_nxt  = rem_v;
    quot_nxt = {quot_r[MAG_W-DIV_STEP-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == DIV_CNT_W'(DIV_CYCLES - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath registers: load on start, advance while busy
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dsor_r <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

FILE: hdl/signed_to_radix_digits.sv
// Signed 64-bit integer to ASCII text in radix 2..36, most significant character first.
// Each digit takes one pass of the shared divider (start, 8 steps of 8 quotient
//   bits, hand-off); after the last digit the sign, if any, goes out, then each digit
//   is read from the digit store (S_RD) and emitted (S_EMIT). Zero emits one '0'.
// Flow: one word at a time, in_tready high only while idle; out_tready low stalls
//   the character output. Reset: rst_n sync low clears sequencer.
module signed_to_radix_digits
  import s2rd_pkg::*;
#(
  parameter int MAX_DIGITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [63:0] value (signed), [69:64] radix, rest zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] character
  output logic                   out_tlast   // last character of this number
);

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  // Stop extracting once MAX_DIGITS-1 digits are stored (room for the sign)
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_DIGITS - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZERO,
    S_DIV,
    S_SIGN,
    S_RD,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [MAG_W-1:0]     mag_r;
  logic [RADIX_W-1:0]   radix_r;
  logic                 neg_r;
  logic [ADDR_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]    rd_idx_r;
  logic [RADIX_W-1:0]   rd_data_r;
  logic                 div_start_r;
  logic                 out_tvalid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [RADIX_W-1:0]   digit_mem [MAX_DIGITS];

  div_res_t             div_res;

  // Decode the incoming word: saturate radix, take magnitude
  logic [MAG_W-1:0]     in_value;
  logic [RADIX_W-1:0]   in_radix_raw;
  logic [RADIX_W-1:0]   in_radix;
  logic [MAG_W-1:0]     in_neg_mag;
  logic [MAG_W-1:0]     in_mag;
  logic                 slot_free;
  logic                 div_last;
  logic                 div_go;
  logic                 out_load;

  assign in_value     = in_tdata[MAG_W-1:0];
  assign in_radix_raw = in_tdata[MAG_W+RADIX_W-1:MAG_W];

  always_comb begin
    in_radix = in_radix_raw;
    if (in_radix_raw < RADIX_MIN) begin
      in_radix = RADIX_MIN;
    end else if (in_radix_raw > RADIX_MAX) begin
      in_radix = RADIX_MAX;
    end
  end

  // The most negative value negates to itself; clamp it to the largest magnitude
  assign in_neg_mag = ~in_value + 1'b1;
  assign in_mag = !in_value[MAG_W-1]       ? in_value :
                  in_neg_mag[MAG_W-1]      ? MAG_MAX  : in_neg_mag;

  // Output register can take a new character if empty or draining this cycle
  assign slot_free = !out_tvalid_r || out_tready;

  // Stop after this digit when the quotient runs out or the store is full
  assign div_last = (div_res.quot == '0) || (cnt_r == LAST_SLOT);

  // Kick the divider on a nonzero accept and after every digit but the last
  assign div_go = (state_r == S_IDLE && in_tvalid && in_mag != '0) ||
                  (state_r == S_DIV && div_res.done && !div_last);

  // Load a character word into the output register
  assign out_load = slot_free && (state_r == S_ZERO || state_r == S_EMIT ||
                                  (state_r == S_SIGN && neg_r));

  s2rd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (mag_r),
    .divisor  (radix_r),
    .res      (div_res)
  );

  // Sequencer: zero gives one '0'; else extract digits LSB first, then the sign and the digits MSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      mag_r        <= '0;
      radix_r      <= RADIX_MIN;
      neg_r        <= 1'b0;
    end else begin
      div_start_r <= div_go;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            radix_r <= in_radix;
            neg_r   <= in_value[MAG_W-1];
            mag_r   <= in_mag;
            cnt_r   <= '0;
            if (in_mag == '0) begin
              state_r <= S_ZERO;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_ZERO: begin
          if (slot_free) begin
            out_char_r <= ASCII_ZERO;
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            mag_r <= div_res.quot;
            cnt_r <= cnt_r + 1'b1;
            if (div_last) begin
              rd_idx_r <= cnt_r;
              state_r  <= S_SIGN;
            end
          end
        end
        S_SIGN: begin
          if (!neg_r) begin
            state_r <= S_RD;
          end else if (slot_free) begin
            out_char_r <= ASCII_MINUS;
            out_last_r <= 1'b0;
            state_r    <= S_RD;
          end
        end
        S_RD: begin
          // digit memory read lands in rd_data_r this edge
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_char_r <= digit_to_ascii(rd_data_r);
            out_last_r <= (rd_idx_r == '0);
            if (rd_idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r - 1'b1;
              state_r  <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Digit store: write each remainder as it comes out, registered read
  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_res.done) begin
      digit_mem[cnt_r] <= div_res.rem;
    end
    rd_data_r <= digit_mem[rd_idx_r];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: bench/signed_to_radix_digits_tb.sv
// Self-checking bench for signed_to_radix_digits: random and corner words, digit text scored.
module signed_to_radix_digits_tb
  import s2rd_pkg::*;
();

  localparam int DIGIT_LIMIT  = 64;        // MAX_DIGITS of the instance
  localparam int CYCLE_LIMIT  = 1000000;   // watchdog; the slowest legal run is far below
  localparam int DRAIN_CYCLES = 64;        // quiet time after the last expected word
  localparam int RANDOM_WORDS = 140;
  localparam int PHASES       = 4;
  localparam int REPORT_CAP   = 100;       // print at most this many mismatches
  localparam int NUMERALS     = 10;        // digit values below this render as '0'..'9'

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Predicts the character stream of each accepted number and scores the outputs.
  class digit_text_board;
    text_char_t  pending_chars[$];
    int unsigned mismatches = 0;
    int unsigned reports    = 0;

    // Render value in radix (saturated to 2..36) and queue its characters.
    function void note_word(logic [MAG_W-1:0] value, logic [RADIX_W-1:0] radix);
      logic [MAG_W-1:0]   mag;
      logic [MAG_W-1:0]   base;
      logic [RADIX_W-1:0] digits[$];
      logic [RADIX_W-1:0] d;
      text_char_t         c;
      if (radix < RADIX_MIN) begin
        base = MAG_W'(RADIX_MIN);
      end else if (radix > RADIX_MAX) begin
        base = MAG_W'(RADIX_MAX);
      end else begin
        base = MAG_W'(radix);
      end
      mag = value[MAG_W-1] ? (~value + 1'b1) : value;
      // the most negative number has no positive twin: clamp it
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
      if (mag == '0) begin
        c.code = ASCII_ZERO;
        c.last = 1'b1;
        pending_chars.push_back(c);
        return;
      end
      while (mag != '0 && digits.size() < DIGIT_LIMIT - 1) begin
        digits.push_back(RADIX_W'(mag % base));
        mag = mag / base;
      end
      if (value[MAG_W-1]) begin
        c.code = ASCII_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
        d = digits[i];
        c.code = (d < NUMERALS) ? ASCII_ZERO + CHAR_W'(d) : ASCII_A + CHAR_W'(d - NUMERALS);
        c.last = (i == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (reports < REPORT_CAP) begin
        reports++;
        $display("%0t: %s", $time, what);
      end
    endfunction

    // Compare one emitted character against the oldest prediction.
    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t exp_c;
      if (pending_chars.size() == 0) begin
        flag($sformatf("unexpected character: expected none, got %h last %0b", code, last));
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code) begin
        flag($sformatf("character: expected %h, got %h", exp_c.code, code));
      end
      if (last !== exp_c.last) begin
        flag($sformatf("last flag: expected %0b, got %0b", exp_c.last, last));
      end
    endfunction

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [63:0] value, [69:64] radix, [71:70] zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [7:0] character
  logic                   out_tlast;

  int unsigned     src_idle_pct   = 0;
  int unsigned     sink_stall_pct = 0;
  int unsigned     cycle_count    = 0;
  digit_text_board board = new();

  // Idle/stall percentages per random phase: none, sender, receiver, both
  int unsigned phase_src[PHASES]  = '{0, 81, 0, 19};
  int unsigned phase_sink[PHASES] = '{0, 0, 81, 19};

  // Corner words: zero, unit, extremes, clamped minimum, saturated radix, letter digits
  localparam int DIRECTED = 22;
  logic [MAG_W-1:0] dir_value[DIRECTED] = '{
    64'd0, 64'd1, -64'd1, -64'd1,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
    64'd35, 64'd36, -64'd1295, 64'd255, 64'd10, 64'd12345, -64'd12345,
    64'd100, 64'd100, 64'd9, 64'd0, 64'd0
  };
  logic [RADIX_W-1:0] dir_radix[DIRECTED] = '{
    6'd10, 6'd2, 6'd10, 6'd2,
    6'd2, 6'd2, 6'd2,
    6'd16, 6'd36, 6'd36,
    6'd36, 6'd36, 6'd36, 6'd16, 6'd16, 6'd0, 6'd1,
    6'd63, 6'd37, 6'd10, 6'd0, 6'd63
  };

  signed_to_radix_digits #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: end the run if the block hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: decide readiness once per falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Score every character word taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_char(out_tdata, out_tlast);
    end
  end

  // Present one number; call at a falling edge, return at a falling edge with valid held.
  task automatic send_word(input logic [MAG_W-1:0] value, input logic [RADIX_W-1:0] radix);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, radix, value};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    board.note_word(value, radix);
    @(negedge clk);
  endtask

  // Mix full-width, shortened and small magnitudes, each with either sign.
  function automatic logic [MAG_W-1:0] pick_value();
    logic [MAG_W-1:0] v;
    int unsigned      shape;
    shape = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    if (shape >= 4 && shape < 7) begin
      v = v >> $urandom_range(1, 63);
    end else if (shape >= 7) begin
      v = MAG_W'($urandom_range(0, 1000));
    end
    if (shape >= 4 && $urandom_range(0, 1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // Mostly legal radixes; the rest spans the whole field to hit saturation.
  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) < 8) begin
      return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    rst_n      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners with no idling
    for (int i = 0; i < DIRECTED; i++) begin
      send_word(dir_value[i], dir_radix[i]);
    end

    // random words across the idling phases
    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      for (int k = 0; k < RANDOM_WORDS / PHASES; k++) begin
        send_word(pick_value(), pick_radix());
      end
    end
    in_tvalid <= 1'b0;

    // drain: wait for every predicted character, then watch for strays
    while (board.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/s2rd_pkg.sv
hdl/s2rd_divider.sv
hdl/signed_to_radix_digits.sv
bench/signed_to_radix_digits_tb.sv
